// ===== rtl/core/wstd_pkg.sv =====
// Shared types and constants for the weighted server task dispatch unit.
// Used by wstd_cell and weighted_server_task_dispatch_unit; depends on nothing.
`timescale 1ns / 1ps

package wstd_pkg;

  localparam int SRV_IDX_W = 6;
  localparam int TIME_W    = 32;
  localparam int WEIGHT_W  = 16;
  localparam int DUR_W     = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TASK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 tok;
    logic                 valid;
    logic                 free;
    logic [WEIGHT_W-1:0]  weight;
    logic [TIME_W-1:0]    ftime;
    logic [SRV_IDX_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic                 wt_en;
    logic [SRV_IDX_W-1:0] wt_sel;
    logic [WEIGHT_W-1:0]  wt_value;
    logic                 ft_en;
    logic [SRV_IDX_W-1:0] ft_sel;
    logic [TIME_W-1:0]    ft_value;
  } upd_t;

endpackage

// ===== rtl/core/weighted_server_task_dispatch_unit.sv =====
// Top level of the weighted server task dispatch unit: control, arrival counter, results.
// Depends on wstd_pkg and wstd_cell.
//
//   channel | handshake          | payload
//   in      | in_valid, in_stall | func, server_sel, weight_value, task_duration
//   out     | out_valid,out_stall| assigned_server, start_second, time_saturated
//
// A weight load gives no result.
// A task passes through the start register, then one register per server cell as the
// best candidate walks the chain, then the control seeing the end of the chain,
// and then the write-back of the winner's free time.
// Reset clears all weights, free times and the arrival counter.
// A finished result waits in the output register; a new request is taken meanwhile,
// and a task finishing while that register is still stalled waits for it.
`timescale 1ns / 1ps

module weighted_server_task_dispatch_unit #(
  parameter int NUM_SERVERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [2:0]  server_sel,
  input  logic [15:0] weight_value,
  input  logic [15:0] task_duration,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  assigned_server,
  output logic [31:0] start_second,
  output logic        time_saturated
);
  import wstd_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [TIME_W-1:0] arrival;
  logic [DUR_W-1:0]  duration;
  logic              go_q;
  logic              in_take;
  logic              finish;
  upd_t              upd;
  cand_t             chain [NUM_SERVERS+1];
  cand_t             best;
  logic [TIME_W-1:0] start;
  logic [TIME_W:0]   fin;
  logic              sat;

  assign in_stall = state != ST_IDLE;
  assign in_take  = in_valid && !in_stall;
  assign best     = chain[NUM_SERVERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_take && func == FUNC_TASK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (best.tok) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    start = best.free ? arrival : best.ftime;
    fin   = {1'b0, start} + {{(TIME_W+1-DUR_W){1'b0}}, duration};
    sat   = fin[TIME_W] || arrival == TIME_MAX;
  end

  always_comb begin
    upd.wt_en    = in_take && func == FUNC_LOAD;
    upd.wt_sel   = {{(SRV_IDX_W-3){1'b0}}, server_sel};
    upd.wt_value = weight_value;
    upd.ft_en    = finish;
    upd.ft_sel   = best.idx;
    upd.ft_value = fin[TIME_W] ? TIME_MAX : fin[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go_q    <= 1'b0;
      arrival <= '0;
    end else begin
      go_q <= in_take && func == FUNC_TASK;
      if (finish && arrival != TIME_MAX) begin
        arrival <= arrival + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      duration <= task_duration;
    end
  end

  always_comb begin
    chain[0]       = '0;
    chain[0].tok   = go_q;
    chain[0].valid = 1'b0;
  end

  for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_cell
    wstd_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cand_in (chain[g]),
      .arrival (arrival),
      .upd     (upd),
      .cand_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      assigned_server <= best.idx[2:0];
      start_second    <= start;
      time_saturated  <= sat;
    end
  end

endmodule

// ===== rtl/core/wstd_cell.sv =====
// One server cell: holds a weight and a free time, and passes the best candidate on.
// Depends on wstd_pkg.
`timescale 1ns / 1ps

module wstd_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  wstd_pkg::cand_t cand_in,
  input  logic [31:0]     arrival,
  input  wstd_pkg::upd_t  upd,
  output wstd_pkg::cand_t cand_out
);
  import wstd_pkg::*;

  localparam logic [SRV_IDX_W-1:0] MY_IDX = SRV_IDX_W'(CELL_IDX);

  logic [WEIGHT_W-1:0] weight;
  logic [TIME_W-1:0]   free_time;
  logic                tok_q;
  cand_t               data_q;
  cand_t               pick;
  logic                mine_free;
  logic                take;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight    <= '0;
      free_time <= '0;
    end else begin
      if (upd.wt_en && upd.wt_sel == MY_IDX) begin
        weight <= upd.wt_value;
      end
      if (upd.ft_en && upd.ft_sel == MY_IDX) begin
        free_time <= upd.ft_value;
      end
    end
  end

  always_comb begin
    mine_free = free_time <= arrival;
    if (!cand_in.valid) begin
      take = 1'b1;
    end else if (mine_free != cand_in.free) begin
      take = mine_free;
    end else if (mine_free) begin
      take = weight < cand_in.weight;
    end else begin
      take = (free_time < cand_in.ftime) ||
             (free_time == cand_in.ftime && weight < cand_in.weight);
    end
    pick = cand_in;
    if (take) begin
      pick.valid  = 1'b1;
      pick.free   = mine_free;
      pick.weight = weight;
      pick.ftime  = free_time;
      pick.idx    = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= cand_in.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_in.tok) begin
      data_q <= pick;
    end
  end

  always_comb begin
    cand_out     = data_q;
    cand_out.tok = tok_q;
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for weighted_server_task_dispatch_unit: directed and random
// weight loads and task requests against a cycle-free dispatch predictor.
// Depends on wstd_pkg and the RTL of the dispatch unit.
`timescale 1ns / 1ps

module tb;
  import wstd_pkg::*;

  localparam int NSRV = 8;

  typedef struct packed {
    logic [2:0]        server;
    logic [TIME_W-1:0] start;
    logic              sat;
  } dispatch_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [2:0]          server_sel;
  logic [WEIGHT_W-1:0] weight_value;
  logic [DUR_W-1:0]    task_duration;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          assigned_server;
  logic [TIME_W-1:0]   start_second;
  logic                time_saturated;

  logic [TIME_W-1:0]   model_arrival;
  logic [TIME_W-1:0]   model_free_at [NSRV];
  logic [WEIGHT_W-1:0] model_weight [NSRV];
  dispatch_t           dispatch_expected [$];

  int err_count  = 0;
  int burst_left = 0;
  int gap_max    = 0;
  int burst_max  = 1;

  weighted_server_task_dispatch_unit #(.NUM_SERVERS(NSRV)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .server_sel     (server_sel),
    .weight_value   (weight_value),
    .task_duration  (task_duration),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .assigned_server(assigned_server),
    .start_second   (start_second),
    .time_saturated (time_saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic dispatch_t predict_dispatch(input logic [DUR_W-1:0] dur);
    int                best;
    logic [TIME_W:0]   finish;
    logic [TIME_W-1:0] k;
    dispatch_t         r;
    k = model_arrival;
    best = -1;
    for (int s = 0; s < NSRV; s++) begin
      if (model_free_at[s] <= k) begin
        if (best < 0 || model_weight[s] < model_weight[best]) best = s;
      end
    end
    if (best < 0) begin
      best = 0;
      for (int s = 1; s < NSRV; s++) begin
        if (model_free_at[s] < model_free_at[best] ||
            (model_free_at[s] == model_free_at[best] &&
             model_weight[s] < model_weight[best])) best = s;
      end
    end
    r.server = best[2:0];
    r.start  = (model_free_at[best] > k) ? model_free_at[best] : k;
    finish   = {1'b0, r.start} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
    r.sat    = 1'b0;
    if (finish > {1'b0, TIME_MAX}) begin
      finish = {1'b0, TIME_MAX};
      r.sat  = 1'b1;
    end
    model_free_at[best] = finish[TIME_W-1:0];
    if (k == TIME_MAX) r.sat = 1'b1;
    else model_arrival = k + 1;
    return r;
  endfunction

  task automatic send_request(input logic f, input logic [2:0] sel,
                              input logic [WEIGHT_W-1:0] wv, input logic [DUR_W-1:0] dur);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    func          <= f;
    server_sel    <= sel;
    weight_value  <= wv;
    task_duration <= dur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == FUNC_LOAD) begin
      if (sel < NSRV) model_weight[sel] = wv;
    end else begin
      dispatch_expected.push_back(predict_dispatch(dur));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dispatch_expected.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // All servers start free with equal weights, so index zero wins; a zero-length
  // task leaves its server free at the start second.
  task automatic test_reset_defaults();
    send_request(FUNC_TASK, 3'd7, 16'hFFFF, 16'd0);
    send_request(FUNC_TASK, 3'd0, 16'h0000, 16'd1);
  endtask

  task automatic test_weight_loads();
    send_request(FUNC_LOAD, 3'd0, 16'h5555, 16'hFFFF);
    send_request(FUNC_LOAD, 3'd1, 16'hFFFF, 16'h0000);
    send_request(FUNC_LOAD, 3'd2, 16'h00FF, 16'hAAAA);
    send_request(FUNC_LOAD, 3'd3, 16'h0000, 16'h5555);
    send_request(FUNC_LOAD, 3'd4, 16'hAAAA, 16'h0001);
    send_request(FUNC_LOAD, 3'd5, 16'h8000, 16'h8000);
    send_request(FUNC_LOAD, 3'd6, 16'h0001, 16'h00FF);
    send_request(FUNC_LOAD, 3'd7, 16'h0000, 16'hFF00);
  endtask

  // Fill every server so that all become free at the same second, then submit
  // while all are busy so the weight and index tie-breaks decide.
  task automatic test_busy_tie_break();
    logic [DUR_W-1:0] dur;
    for (int i = 0; i < NSRV; i++) begin
      dur = 16'd200 - model_arrival[DUR_W-1:0];
      send_request(FUNC_TASK, 3'(i), 16'(i), dur);
    end
    send_request(FUNC_TASK, 3'd0, 16'h0000, 16'hFFFF);
    send_request(FUNC_TASK, 3'd0, 16'h0000, 16'hAAAA);
    send_request(FUNC_TASK, 3'd0, 16'h0000, 16'h5555);
  endtask

  task automatic test_random_traffic(input int n, input int gaps, input int bursts,
                                     input int dur_max, input bit big_dur);
    logic [WEIGHT_W-1:0] wv;
    logic [DUR_W-1:0]    dur;
    gap_max   = gaps;
    burst_max = bursts;
    repeat (n) begin
      case ($urandom_range(3))
        0:       wv = 16'($urandom_range(3));
        1:       wv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: wv = 16'($urandom);
      endcase
      if ($urandom_range(99) < 15) begin
        send_request(FUNC_LOAD, 3'($urandom), wv, 16'($urandom));
      end else begin
        if ($urandom_range(31) == 0) dur = 16'd0;
        else if (big_dur && $urandom_range(63) == 0) dur = 16'($urandom);
        else dur = 16'($urandom_range(dur_max, 1));
        send_request(FUNC_TASK, 3'($urandom), wv, dur);
      end
    end
  endtask

  always @(posedge clk) begin
    dispatch_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (dispatch_expected.size() == 0) begin
        $error("unexpected result: server %0d start %0d", assigned_server, start_second);
        err_count++;
      end else begin
        exp_r = dispatch_expected.pop_front();
        if (assigned_server !== exp_r.server) begin
          $error("assigned_server: expected %0d, got %0d", exp_r.server, assigned_server);
          err_count++;
        end
        if (start_second !== exp_r.start) begin
          $error("start_second: expected %0d, got %0d", exp_r.start, start_second);
          err_count++;
        end
        if (time_saturated !== exp_r.sat) begin
          $error("time_saturated: expected %0d, got %0d", exp_r.sat, time_saturated);
          err_count++;
        end
      end
    end
  end

  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(256, 32);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(1));
          2:       out_stall <= ($urandom_range(3) != 0);
          default: out_stall <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_LOAD;
    server_sel    = 3'd0;
    weight_value  = 16'd0;
    task_duration = 16'd0;
    model_arrival = '0;
    for (int s = 0; s < NSRV; s++) begin
      model_free_at[s] = '0;
      model_weight[s]  = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_weight_loads();
    test_busy_tie_break();
    drain_results();
    test_random_traffic(500, 0, 1, 12, 1'b0);
    test_random_traffic(500, 12, 6, 24, 1'b0);
    drain_results();
    test_random_traffic(500, 4, 20, 4, 1'b0);
    test_random_traffic(500, 8, 10, 16, 1'b1);

    drain_results();
    repeat (24) @(posedge clk);
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
